>>> hdl/hpt_pkg.sv
// Shared constants and types for the homogeneous point transform core.
// Depends on nothing; every other file imports it.
package hpt_pkg;

  localparam int CoordWidth  = 32;
  localparam int FracBits    = 16;
  localparam int EntryWidth  = 32;
  localparam int NumRegs     = 8;
  localparam int RegWidth    = 2 * EntryWidth;
  localparam int RegSelWidth = $clog2(NumRegs);
  localparam int CfgIdxWidth = RegSelWidth + 1;

  localparam int ProdWidth = EntryWidth + CoordWidth;
  localparam int AccWidth  = EntryWidth + CoordWidth + 3;
  localparam int NumWidth  = AccWidth + FracBits;
  localparam int RemWidth  = AccWidth + 1;
  localparam int DivSteps  = CoordWidth;

  localparam logic [EntryWidth-1:0] FixOne = EntryWidth'(1) << FracBits;
  localparam logic [EntryWidth-1:0] FixZero = '0;

  // Divisor used when w is zero: dividing by 2^(2*FracBits) turns the
  // shifted numerator back into the plain truncated coordinate.
  localparam logic [AccWidth-1:0] SkipDen = AccWidth'(1) << (2 * FracBits);

  localparam logic [RegWidth-1:0] RegReset [NumRegs] = '{
    {FixOne, FixZero}, {FixZero, FixZero},
    {FixZero, FixOne}, {FixZero, FixZero},
    {FixZero, FixZero}, {FixOne, FixZero},
    {FixZero, FixZero}, {FixZero, FixOne}
  };

  typedef logic [3:0][3:0][EntryWidth-1:0] matrix_t;

  typedef struct packed {
    logic [2:0][CoordWidth-1:0] coord;
    logic                       removed;
  } point_t;

  typedef struct packed {
    logic [3:0][AccWidth-1:0] acc;
    logic                     removed;
  } sum_t;

  typedef struct packed {
    logic [RemWidth-1:0]   rem;
    logic [CoordWidth-1:0] qn;   // low numerator bits shift out, quotient bits shift in
    logic                  neg;
    logic                  ovf;
  } lane_t;

  typedef struct packed {
    lane_t [2:0]         lanes;
    logic [AccWidth-1:0] den;
    logic                skip;
    logic                removed;
  } div_t;

  typedef struct packed {
    logic [2:0][CoordWidth-1:0] coord;
    logic                       removed;
    logic                       skipped;
    logic                       saturated;
  } res_t;

endpackage

>>> hdl/hpt_point_if.sv
// Request channel carrying one input point.
// Depends on hpt_pkg for the coordinate width.
interface hpt_point_if;
  import hpt_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [CoordWidth-1:0] in_x;
  logic signed [CoordWidth-1:0] in_y;
  logic signed [CoordWidth-1:0] in_z;
  logic                         in_removed;
  modport source (output valid, in_x, in_y, in_z, in_removed, input ready);
  modport sink (input valid, in_x, in_y, in_z, in_removed, output ready);
endinterface

>>> hdl/hpt_result_if.sv
// Request channel carrying one transformed point.
// Depends on hpt_pkg for the coordinate width.
interface hpt_result_if;
  import hpt_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [CoordWidth-1:0] out_x;
  logic signed [CoordWidth-1:0] out_y;
  logic signed [CoordWidth-1:0] out_z;
  logic                         out_removed;
  logic                         divide_skipped;
  logic                         saturated;
  modport source (output valid, out_x, out_y, out_z, out_removed, divide_skipped,
                  saturated, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_removed, divide_skipped,
                saturated, output ready);
endinterface

>>> hdl/homogeneous_point_transform_core.sv
// Homogeneous 4x4 point transform with perspective divide, signed Q16.16.
// Pipeline registers: 2 multiply/sum, 1 divide setup, 32 divider stages, 1 out.
// Throughput: one point per cycle unless stalled; one quotient bit per stage.
// Any stage holds only while it is full and the stage after it is stalled.
// Reset empties the pipeline and loads the identity matrix.
module homogeneous_point_transform_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  hpt_point_if.sink                        point_i,
  hpt_result_if.source                     result_o,
  input  logic                             cfg_we_i,
  input  logic [hpt_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [hpt_pkg::RegWidth-1:0]     cfg_data_i
);
  import hpt_pkg::*;

  logic [RegWidth-1:0] regs_q [NumRegs];
  matrix_t             matrix;
  point_t              pt;
  sum_t                sum;
  div_t                div;
  res_t                res;
  logic                sum_v, sum_r, div_v, div_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) regs_q[i] <= RegReset[i];
    end else if (cfg_we_i && !cfg_idx_i[CfgIdxWidth-1]) begin
      regs_q[cfg_idx_i[RegSelWidth-1:0]] <= cfg_data_i;
    end
  end

  // each register holds two neighboring entries of one row, first in the upper half
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        matrix[r][c] = (c % 2 == 0) ? regs_q[r * 2 + c / 2][RegWidth-1:EntryWidth]
                                    : regs_q[r * 2 + c / 2][EntryWidth-1:0];
      end
    end
  end

  assign pt.coord[0] = point_i.in_x;
  assign pt.coord[1] = point_i.in_y;
  assign pt.coord[2] = point_i.in_z;
  assign pt.removed  = point_i.in_removed;

  hpt_mac u_mac (
    .clk_i, .rst_ni,
    .in_valid_i (point_i.valid),
    .in_ready_o (point_i.ready),
    .in_i       (pt),
    .matrix_i   (matrix),
    .out_valid_o(sum_v),
    .out_ready_i(sum_r),
    .out_o      (sum)
  );

  hpt_prep u_prep (
    .clk_i, .rst_ni,
    .in_valid_i (sum_v),
    .in_ready_o (sum_r),
    .in_i       (sum),
    .out_valid_o(div_v),
    .out_ready_i(div_r),
    .out_o      (div)
  );

  hpt_div u_div (
    .clk_i, .rst_ni,
    .in_valid_i (div_v),
    .in_ready_o (div_r),
    .in_i       (div),
    .out_valid_o(result_o.valid),
    .out_ready_i(result_o.ready),
    .out_o      (res)
  );

  assign result_o.out_x          = res.coord[0];
  assign result_o.out_y          = res.coord[1];
  assign result_o.out_z          = res.coord[2];
  assign result_o.out_removed    = res.removed;
  assign result_o.divide_skipped = res.skipped;
  assign result_o.saturated      = res.saturated;
endmodule

>>> hdl/hpt_mac.sv
// Matrix product: one stage of twelve multipliers, one stage of row sums.
// Depends on hpt_pkg.
module hpt_mac (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  hpt_pkg::point_t in_i,
  input  hpt_pkg::matrix_t matrix_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output hpt_pkg::sum_t   out_o
);
  import hpt_pkg::*;

  logic signed [ProdWidth-1:0]  prod_q [4][3];
  logic signed [EntryWidth-1:0] bias_q [4];
  logic                         rem_a_q;
  logic                         va_q, vb_q;
  logic                         en_a, en_b;
  sum_t                         sum_d, sum_q;

  assign en_b       = !vb_q || out_ready_i;
  assign en_a       = !va_q || en_b;
  assign in_ready_o = en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (en_a) va_q <= in_valid_i;
      if (en_b) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= $signed(matrix_i[r][c]) * $signed(in_i.coord[c]);
        end
        bias_q[r] <= $signed(matrix_i[r][3]);
      end
      rem_a_q <= in_i.removed;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sum_d.acc[r] = AccWidth'(prod_q[r][0]) + AccWidth'(prod_q[r][1])
                   + AccWidth'(prod_q[r][2]) + (AccWidth'(bias_q[r]) <<< FracBits);
    end
    sum_d.removed = rem_a_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_b) sum_q <= sum_d;
  end

  assign out_valid_o = vb_q;
  assign out_o       = sum_q;
endmodule

>>> hdl/hpt_prep.sv
// Divide setup: signs, magnitudes, zero-w test, range check, first remainder.
// Depends on hpt_pkg.
module hpt_prep (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hpt_pkg::sum_t in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output hpt_pkg::div_t out_o
);
  import hpt_pkg::*;

  logic signed [AccWidth-1:0] w;
  logic                       wneg, skip;
  logic [AccWidth-1:0]        den;
  div_t                       div_d, div_q;
  logic                       v_q, en;

  assign w    = $signed(in_i.acc[3]);
  assign wneg = w[AccWidth-1];
  assign skip = (w == '0);
  assign den  = skip ? SkipDen : (wneg ? AccWidth'(-w) : AccWidth'(w));

  for (genvar c = 0; c < 3; c++) begin : g_lane
    logic signed [AccWidth-1:0] a;
    logic [AccWidth-1:0]        amag;
    logic [NumWidth-1:0]        num;
    logic                       ovf;
    assign a    = $signed(in_i.acc[c]);
    assign amag = a[AccWidth-1] ? AccWidth'(-a) : AccWidth'(a);
    assign num  = {amag, {FracBits{1'b0}}};
    // quotient reaches 2^CoordWidth: clamp regardless of the low bits
    assign ovf  = (NumWidth'(num[NumWidth-1:CoordWidth]) >= NumWidth'(den));
    assign div_d.lanes[c].ovf = ovf;
    assign div_d.lanes[c].rem = ovf ? '0 : RemWidth'(num[NumWidth-1:CoordWidth]);
    assign div_d.lanes[c].qn  = num[CoordWidth-1:0];
    assign div_d.lanes[c].neg = skip ? a[AccWidth-1] : (a[AccWidth-1] ^ wneg);
  end

  assign div_d.den     = den;
  assign div_d.skip    = skip;
  assign div_d.removed = in_i.removed;

  assign en         = !v_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) div_q <= div_d;
  end

  assign out_valid_o = v_q;
  assign out_o       = div_q;
endmodule

>>> hdl/hpt_div.sv
// Pipelined restoring divider, one quotient bit per stage, three lanes
// sharing one divisor, followed by the clamp and output register.
// Depends on hpt_pkg.
module hpt_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hpt_pkg::div_t in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output hpt_pkg::res_t out_o
);
  import hpt_pkg::*;

  localparam logic [CoordWidth-1:0] MaxPos = {1'b0, {(CoordWidth-1){1'b1}}};
  localparam logic [CoordWidth-1:0] MinNeg = {1'b1, {(CoordWidth-1){1'b0}}};

  function automatic lane_t div_step(lane_t l, logic [AccWidth-1:0] den);
    logic [RemWidth-1:0] t;
    logic                bit_q;
    lane_t               r;
    t     = {l.rem[RemWidth-2:0], l.qn[CoordWidth-1]};
    bit_q = (t >= RemWidth'(den));
    r     = l;
    r.rem = bit_q ? t - RemWidth'(den) : t;
    r.qn  = {l.qn[CoordWidth-2:0], bit_q};
    return r;
  endfunction

  div_t              st_q [DivSteps];
  logic [DivSteps-1:0] v_q;
  logic [DivSteps:0]   en;
  logic              ov_q;
  res_t              res_d, res_q;

  assign en[DivSteps] = !ov_q || out_ready_i;
  assign in_ready_o   = en[0];

  for (genvar k = 0; k < DivSteps; k++) begin : g_stage
    div_t src, nxt;
    logic src_v;
    if (k == 0) begin : g_first
      assign src   = in_i;
      assign src_v = in_valid_i;
    end else begin : g_rest
      assign src   = st_q[k-1];
      assign src_v = v_q[k-1];
    end
    always_comb begin
      nxt = src;
      for (int c = 0; c < 3; c++) nxt.lanes[c] = div_step(src.lanes[c], src.den);
    end
    assign en[k] = !v_q[k] || en[k+1];
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= src_v;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en[k]) st_q[k] <= nxt;
    end
  end

  // clamp each quotient to the signed coordinate range
  always_comb begin
    logic [CoordWidth-1:0] q;
    logic                  sat;
    res_d.saturated = 1'b0;
    for (int c = 0; c < 3; c++) begin
      q = st_q[DivSteps-1].lanes[c].qn;
      if (st_q[DivSteps-1].lanes[c].neg) begin
        sat            = st_q[DivSteps-1].lanes[c].ovf || (q > MinNeg);
        res_d.coord[c] = sat ? MinNeg : CoordWidth'(-q);
      end else begin
        sat            = st_q[DivSteps-1].lanes[c].ovf || q[CoordWidth-1];
        res_d.coord[c] = sat ? MaxPos : q;
      end
      res_d.saturated = res_d.saturated | sat;
    end
    res_d.removed = st_q[DivSteps-1].removed;
    res_d.skipped = st_q[DivSteps-1].skip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en[DivSteps]) begin
      ov_q <= v_q[DivSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[DivSteps]) res_q <= res_d;
  end

  assign out_valid_o = ov_q;
  assign out_o       = res_q;

  a_skip_den : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] && st_q[0].skip |-> st_q[0].den == SkipDen)
    else $error("zero-w item without the unit divisor");

  a_den_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] |-> st_q[0].den != '0)
    else $error("divider stage holds a zero divisor");

  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[DivSteps-1] |->
      (st_q[DivSteps-1].lanes[0].rem < RemWidth'(st_q[DivSteps-1].den)) &&
      (st_q[DivSteps-1].lanes[1].rem < RemWidth'(st_q[DivSteps-1].den)) &&
      (st_q[DivSteps-1].lanes[2].rem < RemWidth'(st_q[DivSteps-1].den)))
    else $error("final remainder not below divisor");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ready_i |=> ov_q && $stable(res_q))
    else $error("stalled result changed");
endmodule

>>> tb/sv/homogeneous_point_transform_core_tb.sv
// Testbench for the homogeneous point transform core: random and directed points
// through a 4x4 matrix with perspective divide, checked against a local predictor.
// Depends on hpt_pkg, hpt_point_if, hpt_result_if and the core itself.
`timescale 1ns / 100ps

module homogeneous_point_transform_core_tb;
  import hpt_pkg::*;

  localparam int MatrixRegs = 8;
  localparam int IdleLimit  = 2000;
  localparam logic [CfgIdxWidth-1:0] RegRow0Left  = 0;
  localparam logic [CfgIdxWidth-1:0] RegRow3Left  = 6;
  localparam logic [CfgIdxWidth-1:0] RegRow3Right = 7;
  localparam logic [CfgIdxWidth-1:0] RegOutside   = 8;

  typedef struct packed {
    logic [31:0] x, y, z;
    logic        removed;
  } pt_t;

  typedef struct packed {
    logic [31:0] x, y, z;
    logic        removed, skipped, sat;
  } xf_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_idx_i = '0;
  logic [RegWidth-1:0] cfg_data_i = '0;

  hpt_point_if  point_if ();
  hpt_result_if result_if ();

  homogeneous_point_transform_core u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .point_i   (point_if.sink),
    .result_o  (result_if.source),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [63:0] matrix_regs [MatrixRegs];
  pt_t pending_points [$];
  xf_t expected_points [$];
  int  error_count = 0;
  int  idle_cycles = 0;
  bit  calm = 1'b0;
  int  src_gap = 0, sink_gap = 0;

  function automatic logic signed [31:0] entry_of(int r, int c);
    logic [63:0] rv;
    rv = matrix_regs[r*2 + c/2];
    return (c % 2) ? rv[31:0] : rv[63:32];
  endfunction

  // Exact 128-bit math; divisions done on magnitudes then signed.
  function automatic xf_t transform_point(pt_t p);
    logic signed [127:0] acc [4];
    logic signed [127:0] crd [3];
    logic [127:0] mag, den, q;
    logic neg, wneg, skip;
    xf_t res;
    crd[0] = $signed(p.x);
    crd[1] = $signed(p.y);
    crd[2] = $signed(p.z);
    for (int r = 0; r < 4; r++) begin
      acc[r] = 128'(entry_of(r, 3)) <<< FracBits;
      for (int c = 0; c < 3; c++) acc[r] += 128'(entry_of(r, c)) * crd[c];
    end
    skip = (acc[3] == 0);
    wneg = acc[3] < 0;
    den = wneg ? -acc[3] : acc[3];
    res.sat = 1'b0;
    for (int c = 0; c < 3; c++) begin
      neg = acc[c] < 0;
      mag = neg ? -acc[c] : acc[c];
      if (skip) q = mag >> FracBits;
      else begin
        q = (mag << FracBits) / den;
        neg = neg ^ wneg;
      end
      if (q == 0) neg = 1'b0;
      if (!neg && q > 128'h7fff_ffff) begin
        q = 128'h7fff_ffff;
        res.sat = 1'b1;
      end else if (neg && q > 128'h8000_0000) begin
        q = 128'h8000_0000;
        res.sat = 1'b1;
      end else if (neg) q = -q;
      case (c)
        0: res.x = q[31:0];
        1: res.y = q[31:0];
        default: res.z = q[31:0];
      endcase
    end
    res.removed = p.removed;
    res.skipped = skip;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Driver: present the oldest pending point; hold a stalled request until taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (point_if.valid && point_if.ready) begin
        expected_points.push_back(transform_point(pending_points.pop_front()));
      end
      if (src_gap > 0) src_gap <= src_gap - 1;
      else if (!calm && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 11);
      if (pending_points.size() > 0 &&
          (src_gap == 0 || calm || (point_if.valid && !point_if.ready))) begin
        point_if.valid      <= 1'b1;
        point_if.in_x       <= pending_points[0].x;
        point_if.in_y       <= pending_points[0].y;
        point_if.in_z       <= pending_points[0].z;
        point_if.in_removed <= pending_points[0].removed;
      end else begin
        point_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    xf_t want;
    if (rst_ni) begin
      if (result_if.valid && result_if.ready) begin
        if (expected_points.size() == 0) begin
          $display("unexpected result at %0t", $realtime);
          error_count++;
        end else begin
          want = expected_points.pop_front();
          if (result_if.out_x !== want.x) report_mismatch("x", result_if.out_x, want.x);
          if (result_if.out_y !== want.y) report_mismatch("y", result_if.out_y, want.y);
          if (result_if.out_z !== want.z) report_mismatch("z", result_if.out_z, want.z);
          if (result_if.out_removed !== want.removed)
            report_mismatch("removed", 32'(result_if.out_removed), 32'(want.removed));
          if (result_if.divide_skipped !== want.skipped)
            report_mismatch("skipped", 32'(result_if.divide_skipped), 32'(want.skipped));
          if (result_if.saturated !== want.sat)
            report_mismatch("saturated", 32'(result_if.saturated), 32'(want.sat));
        end
      end
      if (sink_gap > 0) sink_gap <= sink_gap - 1;
      else if (!calm && $urandom_range(0, 9) == 0) sink_gap <= $urandom_range(1, 11);
      result_if.ready <= calm || sink_gap == 0;
    end
  end

  // Watchdog: count cycles with no request moving on either side.
  always @(posedge clk_i) begin
    if ((point_if.valid && point_if.ready) || (result_if.valid && result_if.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("homogeneous_point_transform_core_tb: errors");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 1) ? 32'(int'($urandom_range(0, 20)) << 16)
                                     : -32'(int'($urandom_range(0, 20)) << 16);
      3: return 32'($urandom_range(0, 2000)) - 32'd1000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return 32'h0001_0000;
      1: return 32'h0;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return 32'($urandom_range(0, 262144)) - 32'd131072;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic rm);
    pt_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    p.removed = rm;
    pending_points.push_back(p);
  endtask

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx < MatrixRegs) matrix_regs[idx] = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait for the pipeline to drain before touching the matrix.
  task automatic drain();
    while (pending_points.size() > 0 || expected_points.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic random_points(int n);
    for (int i = 0; i < n; i++)
      add_point(rand_coord(), rand_coord(), rand_coord(), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    logic [63:0] v;
    point_if.valid = 1'b0;
    point_if.in_x = '0;
    point_if.in_y = '0;
    point_if.in_z = '0;
    point_if.in_removed = 1'b0;
    result_if.ready = 1'b0;
    for (int i = 0; i < MatrixRegs; i++) matrix_regs[i] = RegReset[i];
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Identity matrix: extremes, removed mark, zero.
    add_point(32'h8000_0000, 32'h7fff_ffff, 32'h0, 1'b1);
    add_point(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 1'b0);
    add_point(32'h0001_0000, 32'hffff_0000, 32'h0000_8000, 1'b1);
    drain();

    // Zero w row: divide skipped, including the saturating case.
    write_reg(RegRow3Left, 64'h0);
    write_reg(RegRow3Right, 64'h0);
    write_reg(RegRow0Left, 64'h7fff_ffff_7fff_ffff);
    add_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    add_point(32'h8000_0000, 32'h8000_0000, 32'h1, 1'b1);
    add_point(32'h1, 32'hffff_ffff, 32'h0, 1'b0);
    drain();

    // Tiny w: quotients overflow both ways; negative w flips sign.
    write_reg(RegRow3Right, 64'h0000_0000_0000_0001);
    add_point(32'h7fff_ffff, 32'h8000_0000, 32'h5, 1'b0);
    drain();
    write_reg(RegRow3Right, 64'h0000_0000_ffff_ffff);
    add_point(32'h0001_0000, 32'h0002_0000, 32'hffff_0000, 1'b1);
    drain();
    write_reg(RegOutside, 64'hdead_beef_dead_beef);
    write_reg(RegRow3Right, 64'h0000_0000_0001_0000);

    // Random phases: random matrices, then extremes.
    for (int ph = 0; ph < 12; ph++) begin
      for (int r = 0; r < MatrixRegs; r++) begin
        v = {rand_entry(), rand_entry()};
        if (ph == 10) v = '1;
        if (ph == 11) v = {32'h8000_0000, 32'h7fff_ffff};
        write_reg(CfgIdxWidth'(r), v);
      end
      if (ph == 11) calm = 1'b1;
      random_points(125);
      drain();
    end

    if (error_count == 0) begin
      $display("homogeneous_point_transform_core_tb: clean");
    end else begin
      $display("homogeneous_point_transform_core_tb: errors");
    end
    $finish;
  end

endmodule
